// File: src/mips_instruction_decoder_macros.svh
// Assertion macros shared by the decoder RTL.
// SYNTH builds see empty bodies.
`ifndef MIPS_INSTRUCTION_DECODER_MACROS_SVH
`define MIPS_INSTRUCTION_DECODER_MACROS_SVH

`ifndef SYNTH

// Checked only while out of reset
`define MID_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every edge, reset included
`define MID_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MID_ASSERT(lbl, clk, rstn, prop, msg)
`define MID_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: src/mipsdec_pkg.sv
package mipsdec_pkg;

  // Major opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_SPECIAL2 = 6'h1C;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2B;

  // SPECIAL funct codes
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SLLV    = 6'h04;
  localparam logic [5:0] FN_SRLV    = 6'h06;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_SLT     = 6'h2A;

  // REGIMM rt selectors
  localparam logic [4:0] RI_BLTZ = 5'd0;
  localparam logic [4:0] RI_BGEZ = 5'd1;

  typedef enum logic [5:0] {
    MN_NONE    = 6'd0,
    MN_ADD     = 6'd1,
    MN_SUB     = 6'd2,
    MN_AND     = 6'd3,
    MN_OR      = 6'd4,
    MN_XOR     = 6'd5,
    MN_SLLV    = 6'd6,
    MN_SRLV    = 6'd7,
    MN_SLT     = 6'd8,
    MN_SLL     = 6'd9,
    MN_SRL     = 6'd10,
    MN_JR      = 6'd11,
    MN_SYSCALL = 6'd12,
    MN_MUL     = 6'd13,
    MN_ADDI    = 6'd14,
    MN_ANDI    = 6'd15,
    MN_ORI     = 6'd16,
    MN_XORI    = 6'd17,
    MN_SLTI    = 6'd18,
    MN_LUI     = 6'd19,
    MN_LB      = 6'd20,
    MN_LH      = 6'd21,
    MN_LW      = 6'd22,
    MN_SB      = 6'd23,
    MN_SH      = 6'd24,
    MN_SW      = 6'd25,
    MN_BEQ     = 6'd26,
    MN_BNE     = 6'd27,
    MN_BLEZ    = 6'd28,
    MN_BGTZ    = 6'd29,
    MN_BLTZ    = 6'd30,
    MN_BGEZ    = 6'd31,
    MN_J       = 6'd32,
    MN_JAL     = 6'd33
  } mnem_t;

  // One decoded result
  typedef struct packed {
    logic [25:0]        jump_target;
    logic signed [15:0] immediate_value;
    logic [4:0]         third_register;
    logic [4:0]         second_register;
    logic [4:0]         first_register;
    mnem_t              mnemonic_code;
  } dec_t;

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 64;

endpackage

// File: src/mipsdec_decode.sv
module mipsdec_decode
  import mipsdec_pkg::*;
(
  input  logic [31:0] word,
  output dec_t        dec
);

  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sa;
  logic [15:0] imm;
  logic [25:0] tgt;

  assign op  = word[31:26];
  assign rs  = word[25:21];
  assign rt  = word[20:16];
  assign rd  = word[15:11];
  assign sa  = word[10:6];
  assign fn  = word[5:0];
  assign imm = word[15:0];
  assign tgt = word[25:0];

  // Field selection per opcode; anything unknown leaves all fields zero
  always_comb begin
    dec = '0;
    unique case (op)
      OP_SPECIAL: begin
        unique case (fn)
          FN_ADD:     dec = '{26'd0, 16'sd0, rt, rs, rd, MN_ADD};
          FN_SUB:     dec = '{26'd0, 16'sd0, rt, rs, rd, MN_SUB};
          FN_AND:     dec = '{26'd0, 16'sd0, rt, rs, rd, MN_AND};
          FN_OR:      dec = '{26'd0, 16'sd0, rt, rs, rd, MN_OR};
          FN_XOR:     dec = '{26'd0, 16'sd0, rt, rs, rd, MN_XOR};
          FN_SLLV:    dec = '{26'd0, 16'sd0, rs, rt, rd, MN_SLLV};
          FN_SRLV:    dec = '{26'd0, 16'sd0, rs, rt, rd, MN_SRLV};
          FN_SLT:     dec = '{26'd0, 16'sd0, rt, rs, rd, MN_SLT};
          FN_SLL:     dec = '{26'd0, signed'({11'd0, sa}), 5'd0, rt, rd, MN_SLL};
          FN_SRL:     dec = '{26'd0, signed'({11'd0, sa}), 5'd0, rt, rd, MN_SRL};
          FN_JR:      dec = '{26'd0, 16'sd0, 5'd0, 5'd0, rs, MN_JR};
          FN_SYSCALL: dec = '{26'd0, 16'sd0, 5'd0, 5'd0, 5'd0, MN_SYSCALL};
          default:    dec = '0;
        endcase
      end
      // mul: opcode alone, funct not checked
      OP_SPECIAL2: dec = '{26'd0, 16'sd0, rt, rs, rd, MN_MUL};
      OP_ADDI:     dec = '{26'd0, signed'(imm), 5'd0, rs, rt, MN_ADDI};
      OP_ANDI:     dec = '{26'd0, signed'(imm), 5'd0, rs, rt, MN_ANDI};
      OP_ORI:      dec = '{26'd0, signed'(imm), 5'd0, rs, rt, MN_ORI};
      OP_XORI:     dec = '{26'd0, signed'(imm), 5'd0, rs, rt, MN_XORI};
      OP_SLTI:     dec = '{26'd0, signed'(imm), 5'd0, rs, rt, MN_SLTI};
      OP_LUI:      dec = '{26'd0, signed'(imm), 5'd0, 5'd0, rt, MN_LUI};
      OP_LB:       dec = '{26'd0, signed'(imm), 5'd0, rs, rt, MN_LB};
      OP_LH:       dec = '{26'd0, signed'(imm), 5'd0, rs, rt, MN_LH};
      OP_LW:       dec = '{26'd0, signed'(imm), 5'd0, rs, rt, MN_LW};
      OP_SB:       dec = '{26'd0, signed'(imm), 5'd0, rs, rt, MN_SB};
      OP_SH:       dec = '{26'd0, signed'(imm), 5'd0, rs, rt, MN_SH};
      OP_SW:       dec = '{26'd0, signed'(imm), 5'd0, rs, rt, MN_SW};
      OP_BEQ:      dec = '{26'd0, signed'(imm), 5'd0, rt, rs, MN_BEQ};
      OP_BNE:      dec = '{26'd0, signed'(imm), 5'd0, rt, rs, MN_BNE};
      OP_BLEZ:     dec = '{26'd0, signed'(imm), 5'd0, 5'd0, rs, MN_BLEZ};
      OP_BGTZ:     dec = '{26'd0, signed'(imm), 5'd0, 5'd0, rs, MN_BGTZ};
      OP_REGIMM: begin
        priority if (rt == RI_BLTZ) begin
          dec = '{26'd0, signed'(imm), 5'd0, 5'd0, rs, MN_BLTZ};
        end else if (rt == RI_BGEZ) begin
          dec = '{26'd0, signed'(imm), 5'd0, 5'd0, rs, MN_BGEZ};
        end else begin
          dec = '0;
        end
      end
      OP_J:        dec = '{tgt, 16'sd0, 5'd0, 5'd0, 5'd0, MN_J};
      OP_JAL:      dec = '{tgt, 16'sd0, 5'd0, 5'd0, 5'd0, MN_JAL};
      default:     dec = '0;
    endcase
  end

endmodule

// File: src/mipsdec_out_stage.sv
`include "mips_instruction_decoder_macros.svh"

module mipsdec_out_stage
  import mipsdec_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   dec_valid,
  input  dec_t                   dec,
  output logic                   dec_ready,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic out_valid_r;
  logic out_valid_nxt;
  dec_t res_r;

  // Load when empty or when the held result transfers this cycle
  assign dec_ready     = !out_valid_r || out_tready;
  assign out_valid_nxt = dec_ready ? dec_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk) begin
    if (dec_ready && dec_valid) begin
      res_r <= dec;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r};

  // Unknown encodings carry nothing but zeros
  `MID_ASSERT(a_none_zero, clk, rst_n, (out_valid_r && res_r.mnemonic_code == MN_NONE) |-> (res_r == '0), "unrecognised word with non-zero fields")
  // Jump target only on j and jal
  `MID_ASSERT(a_tgt_jump_only, clk, rst_n, (out_valid_r && res_r.jump_target != '0) |-> (res_r.mnemonic_code == MN_J || res_r.mnemonic_code == MN_JAL), "jump target on a non-jump")
  // A result taken with nothing new behind it leaves the stage empty
  `MID_ASSERT(a_drain, clk, rst_n, (out_valid_r && out_tready && !dec_valid) |=> !out_valid_r, "result repeated after transfer")
  // Stage is empty right after reset
  `MID_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_valid_r, "output valid after reset")

endmodule

// File: src/mips_instruction_decoder.sv
// Channel   Ports                      Payload (tdata, lowest bit up)
// input     in_tvalid/in_tready        [31:0] instruction_word
// result    out_tvalid/out_tready      mnemonic_code, first_, second_, third_register,
//                                      immediate_value, jump_target, one pad bit
//
// One word per cycle sustained while out_tready stays high; each word passes the input
// register, then decode into the result register, from which its result is offered.
// Reset (rst_n low, synchronous) empties both registers; no payload is cleared.
// A stalled result holds the input register; the input side stalls only when both
// registers are full and out_tready is low.
module mips_instruction_decoder
  import mipsdec_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] instruction_word
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [5:0] mnemonic_code, [10:6] first_register,
                                             // [15:11] second_register,
                                             // [20:16] third_register,
                                             // [36:21] immediate_value,
                                             // [62:37] jump_target, [63] zero
);

  logic        in_valid_r;
  logic        in_valid_nxt;
  logic [31:0] word_r;
  logic        dec_ready;
  dec_t        dec;

  // Input register advances when it is empty or the result stage can take its word
  assign in_tready    = !in_valid_r || dec_ready;
  assign in_valid_nxt = in_tready ? in_tvalid : in_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      word_r <= in_tdata;
    end
  end

  // Field decode
  mipsdec_decode u_decode (
    .word (word_r),
    .dec  (dec)
  );

  // Result register
  mipsdec_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .dec_valid  (in_valid_r),
    .dec        (dec),
    .dec_ready  (dec_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: test/mips_instruction_decoder_tb.sv
module mips_instruction_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mipsdec_pkg::*;

  // Codes the block does not know, used to build unrecognised words
  localparam logic [5:0] FN_UNKNOWN  = 6'h3F;
  localparam logic [4:0] RI_UNKNOWN  = 5'd2;
  localparam logic [5:0] OP_UNKNOWN  = 6'h3B;

  localparam int RANDOM_WORDS = 1150;
  localparam int CHUNK_WORDS  = 50;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 16;

  localparam logic [15:0] IMM_EDGES [4] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF};

  typedef struct {
    logic [31:0] word;
    int          gap;
    bit          drain_first;
  } fetch_item_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [31:0] instruction_word
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [5:0] mnemonic_code, [10:6] first_register,
                                           // [15:11] second_register, [20:16] third_register,
                                           // [36:21] immediate_value, [62:37] jump_target,
                                           // [63] zero

  fetch_item_t fetch_queue[$];
  dec_t        expected_decodes[$];
  int          error_count = 0;
  int          results_seen = 0;
  int          send_wait = 0;
  fetch_item_t next_item;
  int          stall_left = 0;
  bit          stall_free = 1'b0;
  dec_t        got_decode;
  dec_t        want_decode;
  int          idle_cycles = 0;

  mips_instruction_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(string name, longint unsigned got, longint unsigned want);
    if (got !== want) begin
      report_error($sformatf("result %0d %s: got %0h, want %0h", results_seen, name, got,
                             want));
    end
  endtask

  function automatic dec_t make_result(mnem_t code, logic [4:0] r1, logic [4:0] r2,
                                       logic [4:0] r3, logic [15:0] imm, logic [25:0] tgt);
    dec_t d;
    d.mnemonic_code   = code;
    d.first_register  = r1;
    d.second_register = r2;
    d.third_register  = r3;
    d.immediate_value = imm;
    d.jump_target     = tgt;
    return d;
  endfunction

  // Expected decode of one instruction word
  function automatic dec_t decode_word(logic [31:0] w);
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sa;
    logic [15:0] imm;
    logic [25:0] tgt;
    dec_t        d;
    rs  = w[25:21];
    rt  = w[20:16];
    rd  = w[15:11];
    sa  = w[10:6];
    imm = w[15:0];
    tgt = w[25:0];
    d   = make_result(MN_NONE, '0, '0, '0, '0, '0);
    case (w[31:26])
      OP_SPECIAL: begin
        case (w[5:0])
          FN_ADD:     d = make_result(MN_ADD, rd, rs, rt, '0, '0);
          FN_SUB:     d = make_result(MN_SUB, rd, rs, rt, '0, '0);
          FN_AND:     d = make_result(MN_AND, rd, rs, rt, '0, '0);
          FN_OR:      d = make_result(MN_OR, rd, rs, rt, '0, '0);
          FN_XOR:     d = make_result(MN_XOR, rd, rs, rt, '0, '0);
          FN_SLLV:    d = make_result(MN_SLLV, rd, rt, rs, '0, '0);
          FN_SRLV:    d = make_result(MN_SRLV, rd, rt, rs, '0, '0);
          FN_SLT:     d = make_result(MN_SLT, rd, rs, rt, '0, '0);
          FN_SLL:     d = make_result(MN_SLL, rd, rt, '0, {11'b0, sa}, '0);
          FN_SRL:     d = make_result(MN_SRL, rd, rt, '0, {11'b0, sa}, '0);
          FN_JR:      d = make_result(MN_JR, rs, '0, '0, '0, '0);
          FN_SYSCALL: d = make_result(MN_SYSCALL, '0, '0, '0, '0, '0);
          default: ;
        endcase
      end
      OP_SPECIAL2: d = make_result(MN_MUL, rd, rs, rt, '0, '0);
      OP_ADDI:     d = make_result(MN_ADDI, rt, rs, '0, imm, '0);
      OP_ANDI:     d = make_result(MN_ANDI, rt, rs, '0, imm, '0);
      OP_ORI:      d = make_result(MN_ORI, rt, rs, '0, imm, '0);
      OP_XORI:     d = make_result(MN_XORI, rt, rs, '0, imm, '0);
      OP_SLTI:     d = make_result(MN_SLTI, rt, rs, '0, imm, '0);
      OP_LUI:      d = make_result(MN_LUI, rt, '0, '0, imm, '0);
      OP_LB:       d = make_result(MN_LB, rt, rs, '0, imm, '0);
      OP_LH:       d = make_result(MN_LH, rt, rs, '0, imm, '0);
      OP_LW:       d = make_result(MN_LW, rt, rs, '0, imm, '0);
      OP_SB:       d = make_result(MN_SB, rt, rs, '0, imm, '0);
      OP_SH:       d = make_result(MN_SH, rt, rs, '0, imm, '0);
      OP_SW:       d = make_result(MN_SW, rt, rs, '0, imm, '0);
      OP_BEQ:      d = make_result(MN_BEQ, rs, rt, '0, imm, '0);
      OP_BNE:      d = make_result(MN_BNE, rs, rt, '0, imm, '0);
      OP_BLEZ:     d = make_result(MN_BLEZ, rs, '0, '0, imm, '0);
      OP_BGTZ:     d = make_result(MN_BGTZ, rs, '0, '0, imm, '0);
      OP_REGIMM: begin
        if (rt == RI_BLTZ) begin
          d = make_result(MN_BLTZ, rs, '0, '0, imm, '0);
        end else if (rt == RI_BGEZ) begin
          d = make_result(MN_BGEZ, rs, '0, '0, imm, '0);
        end
      end
      OP_J:        d = make_result(MN_J, '0, '0, '0, '0, tgt);
      OP_JAL:      d = make_result(MN_JAL, '0, '0, '0, '0, tgt);
      default: ;
    endcase
    return d;
  endfunction

  // Builds a word for a given mnemonic; the body supplies every bit the encoding leaves free
  function automatic logic [31:0] encode_word(mnem_t m, logic [25:0] body);
    logic [31:0] w;
    case (m)
      MN_ADD:     w = {OP_SPECIAL, body[25:6], FN_ADD};
      MN_SUB:     w = {OP_SPECIAL, body[25:6], FN_SUB};
      MN_AND:     w = {OP_SPECIAL, body[25:6], FN_AND};
      MN_OR:      w = {OP_SPECIAL, body[25:6], FN_OR};
      MN_XOR:     w = {OP_SPECIAL, body[25:6], FN_XOR};
      MN_SLLV:    w = {OP_SPECIAL, body[25:6], FN_SLLV};
      MN_SRLV:    w = {OP_SPECIAL, body[25:6], FN_SRLV};
      MN_SLT:     w = {OP_SPECIAL, body[25:6], FN_SLT};
      MN_SLL:     w = {OP_SPECIAL, body[25:6], FN_SLL};
      MN_SRL:     w = {OP_SPECIAL, body[25:6], FN_SRL};
      MN_JR:      w = {OP_SPECIAL, body[25:6], FN_JR};
      MN_SYSCALL: w = {OP_SPECIAL, body[25:6], FN_SYSCALL};
      MN_MUL:     w = {OP_SPECIAL2, body};
      MN_ADDI:    w = {OP_ADDI, body};
      MN_ANDI:    w = {OP_ANDI, body};
      MN_ORI:     w = {OP_ORI, body};
      MN_XORI:    w = {OP_XORI, body};
      MN_SLTI:    w = {OP_SLTI, body};
      MN_LUI:     w = {OP_LUI, body};
      MN_LB:      w = {OP_LB, body};
      MN_LH:      w = {OP_LH, body};
      MN_LW:      w = {OP_LW, body};
      MN_SB:      w = {OP_SB, body};
      MN_SH:      w = {OP_SH, body};
      MN_SW:      w = {OP_SW, body};
      MN_BEQ:     w = {OP_BEQ, body};
      MN_BNE:     w = {OP_BNE, body};
      MN_BLEZ:    w = {OP_BLEZ, body};
      MN_BGTZ:    w = {OP_BGTZ, body};
      MN_BLTZ:    w = {OP_REGIMM, body[25:21], RI_BLTZ, body[15:0]};
      MN_BGEZ:    w = {OP_REGIMM, body[25:21], RI_BGEZ, body[15:0]};
      MN_J:       w = {OP_J, body};
      MN_JAL:     w = {OP_JAL, body};
      default:    w = {OP_SPECIAL, body[25:6], FN_UNKNOWN};
    endcase
    return w;
  endfunction

  // Reset, stimulus and end of run
  initial begin
    fetch_item_t it;
    logic [25:0] body;
    int          chunk_mode;
    int          pick;

    // Directed: every mnemonic, alternating all-ones and sparse field content
    for (int m = 1; m <= 33; m++) begin
      body = (m % 2) ? '1 : 26'h0008000;
      it.word        = encode_word(mnem_t'(m), body);
      it.gap         = $urandom_range(0, 10);
      it.drain_first = 1'b0;
      fetch_queue.push_back(it);
    end
    // Unknown funct, unknown regimm selector, unknown opcodes, all-zero word
    it.word = encode_word(MN_NONE, '1);
    fetch_queue.push_back(it);
    it.word = {OP_REGIMM, 5'd7, RI_UNKNOWN, 16'h7FFF};
    fetch_queue.push_back(it);
    it.word = {OP_UNKNOWN, 26'h2AAAAAA};
    fetch_queue.push_back(it);
    it.word = '1;
    fetch_queue.push_back(it);
    it.word = '0;
    fetch_queue.push_back(it);

    // Random part in chunks; some chunks run without gaps, some start after a full drain
    chunk_mode = 0;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % CHUNK_WORDS == 0) begin
        chunk_mode = $urandom_range(0, 2);
      end
      body = 26'($urandom);
      if ($urandom_range(0, 7) == 0) begin
        body[15:0] = IMM_EDGES[$urandom_range(0, 3)];
      end
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        it.word = encode_word(mnem_t'($urandom_range(1, 33)), body);
      end else if (pick < 85) begin
        it.word = {OP_SPECIAL, body};
      end else if (pick < 90) begin
        it.word = {OP_REGIMM, body};
      end else begin
        it.word = $urandom;
      end
      it.gap         = (chunk_mode == 0) ? 0 : $urandom_range(0, 10);
      it.drain_first = (i == 0) || (i % CHUNK_WORDS == 0 && $urandom_range(0, 3) == 0);
      fetch_queue.push_back(it);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (fetch_queue.size() != 0 || in_tvalid || expected_decodes.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_decodes.size() != 0) begin
      report_error($sformatf("%0d decodes never returned", expected_decodes.size()));
    end
    if (error_count == 0) begin
      $display("mips_instruction_decoder: match");
    end else begin
      $display("mips_instruction_decoder: mismatch");
    end
    $finish;
  end

  // Driver: one word per transfer, gap before each word, optional drain first
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_decodes.push_back(decode_word(in_tdata));
      end
      if (!(in_tvalid && !in_tready)) begin
        if (send_wait > 0) begin
          send_wait--;
          in_tvalid <= 1'b0;
        end else if (fetch_queue.size() != 0 &&
                     !(fetch_queue[0].drain_first && expected_decodes.size() != 0)) begin
          next_item = fetch_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_item.word;
          send_wait = (fetch_queue.size() != 0) ? fetch_queue[0].gap : 0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer, then stalls for a drawn number of cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_decode = dec_t'(out_tdata[62:0]);
        if (expected_decodes.size() == 0) begin
          report_error($sformatf("unexpected result %0h", out_tdata));
        end else begin
          want_decode = expected_decodes.pop_front();
          check_field("mnemonic_code", got_decode.mnemonic_code, want_decode.mnemonic_code);
          check_field("first_register", got_decode.first_register,
                      want_decode.first_register);
          check_field("second_register", got_decode.second_register,
                      want_decode.second_register);
          check_field("third_register", got_decode.third_register,
                      want_decode.third_register);
          check_field("immediate_value", got_decode.immediate_value,
                      want_decode.immediate_value);
          check_field("jump_target", got_decode.jump_target, want_decode.jump_target);
        end
        check_field("pad bit", out_tdata[63], 1'b0);
        results_seen++;
        if ($urandom_range(0, 99) < 4) begin
          stall_free = !stall_free;
        end
        stall_left = stall_free ? 0 : $urandom_range(0, 10);
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("mips_instruction_decoder: mismatch");
        $finish;
      end
    end
  end

endmodule
